/* rtl/mfc_pkg.sv */
package mfc_pkg;

  typedef enum logic [3:0] {
    MODE_F32  = 4'd0,
    MODE_F64  = 4'd1,
    MODE_I8   = 4'd2,
    MODE_I16  = 4'd3,
    MODE_I32  = 4'd4,
    MODE_I64  = 4'd5,
    MODE_U8   = 4'd6,
    MODE_U16  = 4'd7,
    MODE_U32  = 4'd8,
    MODE_U64  = 4'd9,
    MODE_BOOL = 4'd10
  } mode_e;

  localparam logic [31:0] F32_ONE  = 32'h3F80_0000;
  localparam logic [31:0] F32_ZERO = 32'h0000_0000;
  localparam logic [30:0] F32_INF  = 31'h7F80_0000;
  localparam logic [30:0] F32_QNAN = 31'h7FC0_0000;

  // input word as held in the input register
  typedef struct packed {
    logic        last;
    logic [3:0]  mode;
    logic [63:0] src;
  } in_word_t;

endpackage

/* rtl/mfc_int_cvt.sv */
// Sign/magnitude integer to binary32, round to nearest even.
module mfc_int_cvt (
  input  logic        neg_i,
  input  logic [63:0] mag_i,
  output logic [31:0] res_o
);

  logic [5:0]  p;
  logic [63:0] norm;
  logic [23:0] keep;
  logic        guard;
  logic        sticky;
  logic        rnd_up;
  logic [24:0] keep_r;
  logic [31:0] expo;

  // leading one position
  always_comb begin
    p = 6'd0;
    for (int i = 0; i < 64; i++) begin
      if (mag_i[i]) p = 6'(i);
    end
  end

  // normalize so the leading one sits at bit 63
  assign norm   = mag_i << (6'd63 - p);
  assign keep   = norm[63:40];
  assign guard  = norm[39];
  assign sticky = |norm[38:0];
  assign rnd_up = guard & (sticky | keep[0]);
  assign keep_r = {1'b0, keep} + 25'(rnd_up);
  assign expo   = 32'(8'd126 + 8'(p)) << 23;

  always_comb begin
    if (mag_i == 64'd0) begin
      res_o = 32'd0;
    end else begin
      res_o = {neg_i, 31'd0} | (expo + 32'(keep_r));
    end
  end

endmodule

/* rtl/mfc_f64_cvt.sv */
// binary64 to binary32, round to nearest even.
module mfc_f64_cvt (
  input  logic [63:0] src_i,
  output logic [31:0] res_o
);

  logic        sign;
  logic [10:0] e;
  logic [51:0] f;
  logic [52:0] m;
  logic signed [12:0] ef;
  logic [5:0]  sh;
  logic [63:0] keep;
  logic [63:0] rem;
  logic [63:0] half;
  logic [63:0] mask;
  logic [63:0] keep_r;
  logic [31:0] normal;

  assign sign = src_i[63];
  assign e    = src_i[62:52];
  assign f    = src_i[51:0];
  assign m    = {1'b1, f};
  assign ef   = 13'($signed({2'b00, e})) - 13'sd896;

  // shift is 29 for normals, 30 - ef for results in subnormal range
  // (up to 60, so the rounding terms are kept 64 bits wide)
  assign sh   = (ef >= 13'sd1) ? 6'd29 : 6'(13'sd30 - ef);
  assign keep = {11'd0, m} >> sh;
  assign mask = (64'd1 << sh) - 64'd1;
  assign rem  = {11'd0, m} & mask;
  assign half = 64'd1 << (sh - 6'd1);
  assign keep_r = keep + 64'((rem > half) || ((rem == half) && keep[0]));
  assign normal = (32'(ef - 13'sd1) << 23) + 32'(keep_r);

  always_comb begin
    if (e == 11'h7FF) begin
      if (f == 52'd0) res_o = {sign, mfc_pkg::F32_INF};
      else            res_o = {sign, mfc_pkg::F32_QNAN | {8'd0, f[51:29]}};
    end else if (e == 11'd0) begin
      res_o = {sign, 31'd0};
    end else if (ef >= 13'sd255) begin
      res_o = {sign, mfc_pkg::F32_INF};
    end else if (ef >= 13'sd1) begin
      res_o = {sign, 31'd0} | normal;
    end else if (ef < -13'sd30) begin
      res_o = {sign, 31'd0};
    end else begin
      res_o = {sign, 31'd0} | 32'(keep_r);
    end
  end

endmodule

/* rtl/multi_format_to_float32_converter_top.sv */
// Multi-format to binary32 converter.
// Slave stream: s_axis_tdata carries the 64-bit raw source element, right-
// aligned; s_axis_tuser carries the source-type code; s_axis_tlast marks
// the final element of an array and is passed to m_axis_tlast.
// Master stream: m_axis_tdata is the binary32 pattern of the element.
// The word is loaded into the input register at the accepting edge, then into
// the result register when the pipeline advances; it is valid there until taken.
// Throughput is one word per cycle while the receiver does not stall; the
// single-pass datapath between the two registers sets that figure.
// The pipeline advances whenever the result register is empty or is being
// taken; a stalled receiver holds the result register, and once the input
// register is full too s_axis_tready drops. No word is lost or repeated.
// Reset clears both valid flags; no words are held afterward.
// Unused type codes give a result of zero.
module multi_format_to_float32_converter_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // [63:0] src_bits
  input  logic [3:0]  s_axis_tuser,   // [3:0] mode
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] float_bits
  output logic        m_axis_tlast
);

  mfc_pkg::in_word_t in_q;
  logic              in_vld_q;
  logic [31:0]       res_q;
  logic              last_q;
  logic              out_vld_q;
  logic              adv_out;
  logic              adv_in;

  logic              neg;
  logic [63:0]       mag;
  logic [31:0]       int_res;
  logic [31:0]       f64_res;
  logic [31:0]       res_d;
  logic [63:0]       s;

  assign adv_out = ~out_vld_q | m_axis_tready;
  assign adv_in  = ~in_vld_q | adv_out;
  assign s_axis_tready = adv_in;
  assign s = in_q.src;

  always_comb begin
    neg = 1'b0;
    mag = 64'd0;
    unique case (in_q.mode)
      mfc_pkg::MODE_I8: begin
        neg = s[7];
        mag = {56'd0, s[7] ? 8'(-s[7:0]) : s[7:0]};
        if (s[7:0] == 8'h80) mag = 64'd128;
      end
      mfc_pkg::MODE_I16: begin
        neg = s[15];
        mag = {48'd0, s[15] ? 16'(-s[15:0]) : s[15:0]};
        if (s[15:0] == 16'h8000) mag = 64'd32768;
      end
      mfc_pkg::MODE_I32: begin
        neg = s[31];
        mag = {32'd0, s[31] ? 32'(-s[31:0]) : s[31:0]};
        if (s[31:0] == 32'h8000_0000) mag = 64'h8000_0000;
      end
      mfc_pkg::MODE_I64: begin
        neg = s[63];
        mag = s[63] ? -s : s;
      end
      mfc_pkg::MODE_U8:  mag = {56'd0, s[7:0]};
      mfc_pkg::MODE_U16: mag = {48'd0, s[15:0]};
      mfc_pkg::MODE_U32: mag = {32'd0, s[31:0]};
      mfc_pkg::MODE_U64: mag = s;
      default: ;
    endcase
  end

  mfc_int_cvt u_int_cvt (
    .neg_i (neg),
    .mag_i (mag),
    .res_o (int_res)
  );

  mfc_f64_cvt u_f64_cvt (
    .src_i (s),
    .res_o (f64_res)
  );

  always_comb begin
    unique case (in_q.mode)
      mfc_pkg::MODE_F32:  res_d = s[31:0];
      mfc_pkg::MODE_F64:  res_d = f64_res;
      mfc_pkg::MODE_I8, mfc_pkg::MODE_I16, mfc_pkg::MODE_I32, mfc_pkg::MODE_I64,
      mfc_pkg::MODE_U8, mfc_pkg::MODE_U16, mfc_pkg::MODE_U32, mfc_pkg::MODE_U64:
        res_d = int_res;
      mfc_pkg::MODE_BOOL: res_d = (s[7:0] != 8'd0) ? mfc_pkg::F32_ONE : mfc_pkg::F32_ZERO;
      default:            res_d = mfc_pkg::F32_ZERO;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (adv_in)  in_vld_q  <= s_axis_tvalid;
      if (adv_out) out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_in && s_axis_tvalid) begin
      in_q.src  <= s_axis_tdata;
      in_q.mode <= s_axis_tuser;
      in_q.last <= s_axis_tlast;
    end
    if (adv_out && in_vld_q) begin
      res_q  <= res_d;
      last_q <= in_q.last;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = res_q;
  assign m_axis_tlast  = last_q;

endmodule

/* test/tb.sv */
module tb;

  localparam int unsigned RANDOM_WORDS = 1130;
  localparam int unsigned STALL_LIMIT  = 2000;

  typedef struct packed {
    logic [31:0] bits;
    logic        last;
  } f32_word_t;

  typedef struct {
    logic [3:0]  mode;
    logic [63:0] src;
    logic        last;
    logic        known;
    logic [31:0] bits;
  } vec_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic [3:0]  s_axis_tuser = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tlast;

  f32_word_t   pending_q[$];
  int unsigned err_cnt = 0;
  int unsigned idle_cycles = 0;
  bit          quiet_phase = 1'b0;

  multi_format_to_float32_converter_top dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // round m >> sh to nearest even, sh in 1..63
  function automatic logic [63:0] round_shift(logic [63:0] m, int unsigned sh);
    logic [63:0] keep, rem, half;
    keep = m >> sh;
    rem  = m & ((64'd1 << sh) - 64'd1);
    half = 64'd1 << (sh - 1);
    if (rem > half || (rem == half && keep[0])) keep += 64'd1;
    return keep;
  endfunction

  function automatic logic [31:0] int_to_f32(logic neg, logic [63:0] m);
    int unsigned msb;
    logic [63:0] keep;
    if (m == 0) return 32'd0;
    msb = 0;
    for (int i = 0; i < 64; i++) if (m[i]) msb = i;
    if (msb <= 23) keep = m << (23 - msb);
    else keep = round_shift(m, msb - 23);
    // carry out of rounding bumps the exponent
    return {neg, 31'd0} | 32'((64'(126 + msb) << 23) + keep);
  endfunction

  function automatic logic [31:0] dbl_to_f32(logic [63:0] b);
    logic [31:0] sign;
    logic [10:0] e;
    logic [51:0] f;
    logic [63:0] m;
    int          ef, sh;
    sign = {b[63], 31'd0};
    e = b[62:52];
    f = b[51:0];
    if (e == 11'h7FF) begin
      if (f == 0) return sign | mfc_pkg::F32_INF;
      return sign | mfc_pkg::F32_QNAN | 32'(f >> 29);
    end
    if (e == 0) return sign;
    m = {12'd1, f};
    ef = int'(e) - 1023 + 127;
    if (ef >= 255) return sign | mfc_pkg::F32_INF;
    if (ef >= 1) return sign | 32'((64'(ef - 1) << 23) + round_shift(m, 29));
    sh = 30 - ef;
    if (sh > 60) return sign;
    return sign | 32'(round_shift(m, sh));
  endfunction

  function automatic logic [31:0] convert(logic [3:0] mode, logic [63:0] s);
    case (mode)
      mfc_pkg::MODE_F32:  return s[31:0];
      mfc_pkg::MODE_F64:  return dbl_to_f32(s);
      mfc_pkg::MODE_I8:
        return int_to_f32(s[7], s[7] ? 64'(-s[7:0]) & 64'hFF : 64'(s[7:0]));
      mfc_pkg::MODE_I16:
        return int_to_f32(s[15], s[15] ? 64'(17'h10000 - s[15:0]) : 64'(s[15:0]));
      mfc_pkg::MODE_I32:
        return int_to_f32(s[31], s[31] ? 64'(33'h1_0000_0000 - s[31:0])
                                       : 64'(s[31:0]));
      mfc_pkg::MODE_I64:  return int_to_f32(s[63], s[63] ? -s : s);
      mfc_pkg::MODE_U8:   return int_to_f32(1'b0, 64'(s[7:0]));
      mfc_pkg::MODE_U16:  return int_to_f32(1'b0, 64'(s[15:0]));
      mfc_pkg::MODE_U32:  return int_to_f32(1'b0, 64'(s[31:0]));
      mfc_pkg::MODE_U64:  return int_to_f32(1'b0, s);
      mfc_pkg::MODE_BOOL: return (s[7:0] != 0) ? mfc_pkg::F32_ONE : mfc_pkg::F32_ZERO;
      default:            return 32'd0;
    endcase
  endfunction

  function automatic vec_t row(logic [3:0] mode, logic [63:0] src, logic last,
                               logic known = 1'b0, logic [31:0] bits = '0);
    vec_t v;
    v.mode = mode; v.src = src; v.last = last; v.known = known; v.bits = bits;
    return v;
  endfunction

  // sends one word, with random gaps unless in the quiet phase
  task automatic send_word(logic [3:0] mode, logic [63:0] src, logic last);
    int unsigned gap;
    if (!quiet_phase && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 16);
      if (s_axis_tvalid) s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= src;
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_q.push_back('{convert(mode, src), last});
  endtask

  task automatic drop_valid();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // biased doubles: exponents near the binary32 edges
  function automatic logic [63:0] rand_dbl();
    logic [10:0] e;
    case ($urandom_range(0, 5))
      0: e = 11'(1023 - 126 + $urandom_range(0, 4) - 2);
      1: e = 11'(1023 - 149 + $urandom_range(0, 8) - 4);
      2: e = 11'(1023 + 127 + $urandom_range(0, 2) - 1);
      3: e = ($urandom_range(0, 1) != 0) ? 11'h7FF : 11'h000;
      default: e = 11'($urandom_range(0, 2047));
    endcase
    return {1'($urandom()), e, 20'($urandom()), $urandom()};
  endfunction

  function automatic logic [63:0] rand_src(logic [3:0] mode);
    logic [63:0] s;
    s = rand64();
    if (mode == mfc_pkg::MODE_F64) return rand_dbl();
    // sometimes a value near a rounding tie
    if ($urandom_range(0, 3) == 0) s = s & ~((64'd1 << $urandom_range(0, 40)) - 64'd1);
    if ((mode == mfc_pkg::MODE_BOOL || mode == mfc_pkg::MODE_U8) &&
        $urandom_range(0, 3) == 0) s[7:0] = 8'd0;
    return s;
  endfunction

  // receiver with random stall bursts
  initial begin
    int unsigned stall;
    @(posedge rst_ni);
    forever begin
      if (!quiet_phase && $urandom_range(0, 3) == 0) begin
        stall = $urandom_range(1, 16);
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    f32_word_t exp_w;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_q.size() == 0) begin
          $error("unexpected word: float_bits %h", m_axis_tdata);
          err_cnt++;
        end else begin
          exp_w = pending_q.pop_front();
          if (m_axis_tdata !== exp_w.bits) begin
            $error("float_bits expected %h got %h", exp_w.bits, m_axis_tdata);
            err_cnt++;
          end
          if (m_axis_tlast !== exp_w.last) begin
            $error("last_out expected %b got %b", exp_w.last, m_axis_tlast);
            err_cnt++;
          end
        end
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    vec_t        vecs[$];
    logic [3:0]  mode;
    int unsigned n;
    vecs = '{
      row(mfc_pkg::MODE_F32,  64'hFFFF_FFFF_7FC1_2345, 1'b0, 1'b1, 32'h7FC1_2345),
      row(mfc_pkg::MODE_F32,  64'h0000_0000_FFFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF),
      row(mfc_pkg::MODE_F64,  64'h7FF0_0000_0000_0000, 1'b0, 1'b1, 32'h7F80_0000),
      row(mfc_pkg::MODE_F64,  64'hFFF0_0000_0000_0000, 1'b0, 1'b1, 32'hFF80_0000),
      row(mfc_pkg::MODE_F64,  64'h7FF0_0000_0000_0001, 1'b0, 1'b1, 32'h7FC0_0000),
      row(mfc_pkg::MODE_F64,  64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b1, 32'hFFFF_FFFF),
      row(mfc_pkg::MODE_F64,  64'h8000_0000_0000_0001, 1'b0, 1'b1, 32'h8000_0000),
      row(mfc_pkg::MODE_F64,  64'h3FF0_0000_0000_0000, 1'b0, 1'b1, 32'h3F80_0000),
      row(mfc_pkg::MODE_F64,  64'h47EF_FFFF_F000_0000, 1'b0),
      row(mfc_pkg::MODE_F64,  64'h36A0_0000_0000_0000, 1'b0),
      row(mfc_pkg::MODE_F64,  64'h3690_0000_0000_0001, 1'b0),
      row(mfc_pkg::MODE_I8,   64'hFFFF_FFFF_FFFF_FF80, 1'b0, 1'b1, 32'hC300_0000),
      row(mfc_pkg::MODE_I8,   64'h0000_0000_0000_007F, 1'b0),
      row(mfc_pkg::MODE_I16,  64'h0000_0000_0000_8000, 1'b0, 1'b1, 32'hC700_0000),
      row(mfc_pkg::MODE_I32,  64'h0000_0000_8000_0000, 1'b0, 1'b1, 32'hCF00_0000),
      row(mfc_pkg::MODE_I32,  64'h0000_0000_7FFF_FFFF, 1'b0, 1'b1, 32'h4F00_0000),
      row(mfc_pkg::MODE_I64,  64'h8000_0000_0000_0000, 1'b0, 1'b1, 32'hDF00_0000),
      row(mfc_pkg::MODE_I64,  64'h0000_0000_0100_0001, 1'b0),
      row(mfc_pkg::MODE_U8,   64'hFFFF_FFFF_FFFF_FF00, 1'b0, 1'b1, 32'h0000_0000),
      row(mfc_pkg::MODE_U16,  64'h0000_0000_0000_FFFF, 1'b0),
      row(mfc_pkg::MODE_U32,  64'h0000_0000_FFFF_FFFF, 1'b0, 1'b1, 32'h4F80_0000),
      row(mfc_pkg::MODE_U64,  64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b1, 32'h5F80_0000),
      row(mfc_pkg::MODE_BOOL, 64'hFFFF_FFFF_FFFF_FF00, 1'b0, 1'b1, mfc_pkg::F32_ZERO),
      row(mfc_pkg::MODE_BOOL, 64'h0000_0000_0000_0080, 1'b0, 1'b1, mfc_pkg::F32_ONE),
      row(4'd15,              64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, 32'h0000_0000)
    };
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (vecs[i]) begin
      if (vecs[i].known && convert(vecs[i].mode, vecs[i].src) !== vecs[i].bits) begin
        $error("table row %0d: float_bits expected %h predicted %h", i, vecs[i].bits,
               convert(vecs[i].mode, vecs[i].src));
        err_cnt++;
      end
      send_word(vecs[i].mode, vecs[i].src, vecs[i].last);
    end

    // hold off until the pipe drains
    drop_valid();
    while (pending_q.size() != 0) @(posedge clk_i);

    for (n = 0; n < RANDOM_WORDS; n++) begin
      if (n == RANDOM_WORDS - 150) quiet_phase = 1'b1;
      mode = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(11, 15))
                                          : 4'($urandom_range(0, 10));
      send_word(mode, rand_src(mode), 1'($urandom()));
    end
    drop_valid();

    n = 0;
    while (pending_q.size() != 0 && n < 4000) begin
      @(posedge clk_i);
      n++;
    end
    repeat (5) @(posedge clk_i);
    if (err_cnt == 0 && pending_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* multi_format_to_float32_converter_top.f */
rtl/mfc_pkg.sv
rtl/mfc_int_cvt.sv
rtl/mfc_f64_cvt.sv
rtl/multi_format_to_float32_converter_top.sv
test/tb.sv
